// ===== hw/rtl/pcpa_pkg.sv =====
// ---------------------------------------------------------------------------
// pcpa_pkg
// Shared types, widths and constants of the pacemaker cell phase automaton.
// ---------------------------------------------------------------------------
package pcpa_pkg;

	localparam int VOLT_W    = 24;
	localparam int DT_W      = 16;
	localparam int WAIT_W    = DT_W + 1;
	localparam int PHASE_W   = 3;
	localparam int CFG_IDX_W = 3;
	localparam int NUM_LANES = 4;

	// divide-by-1000 datapath widths
	localparam int AQ_W  = 14;             // |slope| / 1000 < 8389
	localparam int AR_W  = 10;             // |slope| % 1000
	localparam int P1_W  = AQ_W + DT_W;
	localparam int P2_W  = AR_W + DT_W;
	localparam int Q2_W  = DT_W;
	localparam int MAG_W = P1_W;
	localparam int INC_W = MAG_W + 1;
	localparam int SUM_W = INC_W + 1;

	// reciprocals of 1000, exact for 24-bit and 26-bit dividends
	localparam int RECIP_A_W  = 25;
	localparam int RECIP_A_SH = 34;
	localparam logic [RECIP_A_W-1:0] RECIP_A = 25'd17179870;
	localparam int RECIP_B_W  = 27;
	localparam int RECIP_B_SH = 36;
	localparam logic [RECIP_B_W-1:0] RECIP_B = 27'd68719477;

	typedef logic signed [VOLT_W-1:0] volt_t;
	typedef logic signed [INC_W-1:0]  inc_t;

	localparam volt_t VOLT_MAX = 24'sh7FFFFF;
	localparam volt_t VOLT_MIN = -24'sh800000;

	// default values of the top level parameters
	localparam logic [DT_W-1:0] WAIT_MS_DEF     = 16'd1000;
	localparam volt_t           VOLT_FLOOR_DEF  = -24'sd20480;
	localparam volt_t           VOLT_RESET_DEF  = -24'sd17920;
	localparam volt_t           REPOL_SLOPE_DEF = -24'sd51200;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RESTING_SLOPE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PACING_DISABLED = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REST_EXIT       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UPSTROKE_PEAK   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PLATEAU_EXIT    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_REPOL_EXIT      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_UPSTROKE_SLOPE  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_PLATEAU_SLOPE   = 3'd7;

	// increment lanes, one per slope
	localparam logic [1:0] LANE_REST  = 2'd0;
	localparam logic [1:0] LANE_UP    = 2'd1;
	localparam logic [1:0] LANE_PLAT  = 2'd2;
	localparam logic [1:0] LANE_REPOL = 2'd3;

	typedef enum logic [PHASE_W-1:0] {
		PH_REST     = 3'd0,
		PH_UPSTROKE = 3'd1,
		PH_PLATEAU  = 3'd2,
		PH_REPOL    = 3'd3,
		PH_WAIT     = 3'd4
	} phase_t;

	typedef struct packed {
		logic [DT_W-1:0] dt_ms;
		logic            stimulus;
	} in_item_t;

	typedef struct packed {
		logic signed [VOLT_W-1:0] voltage;
		logic [PHASE_W-1:0]       phase;
		logic                     phase_toggle;
	} out_item_t;

	typedef struct packed {
		logic signed [VOLT_W-1:0] resting_slope;
		logic                     pacing_disabled;
		logic signed [VOLT_W-1:0] rest_exit_level;
		logic signed [VOLT_W-1:0] upstroke_peak_level;
		logic signed [VOLT_W-1:0] plateau_exit_level;
		logic signed [VOLT_W-1:0] repol_exit_level;
		logic signed [VOLT_W-1:0] upstroke_slope;
		logic signed [VOLT_W-1:0] plateau_slope;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		resting_slope:       24'sd0,
		pacing_disabled:     1'b0,
		rest_exit_level:     -24'sd15360,
		upstroke_peak_level: -24'sd7680,
		plateau_exit_level:  -24'sd10240,
		repol_exit_level:    -24'sd16640,
		upstroke_slope:      24'sd256000,
		plateau_slope:       -24'sd2560
	};

	// load enables of the increment pipeline stages
	typedef struct packed {
		logic ld2;
		logic ld3;
		logic ld4;
		logic ld5;
	} stage_en_t;

endpackage

// ===== hw/rtl/pcpa_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// pcpa_cfg_regs
// Configuration register file, written through a plain write port.
// ---------------------------------------------------------------------------
module pcpa_cfg_regs import pcpa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [VOLT_W-1:0]    cfg_wdata,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_RESTING_SLOPE:   cfg_q.resting_slope       <= cfg_wdata;
				REG_PACING_DISABLED: cfg_q.pacing_disabled     <= cfg_wdata[0];
				REG_REST_EXIT:       cfg_q.rest_exit_level     <= cfg_wdata;
				REG_UPSTROKE_PEAK:   cfg_q.upstroke_peak_level <= cfg_wdata;
				REG_PLATEAU_EXIT:    cfg_q.plateau_exit_level  <= cfg_wdata;
				REG_REPOL_EXIT:      cfg_q.repol_exit_level    <= cfg_wdata;
				REG_UPSTROKE_SLOPE:  cfg_q.upstroke_slope      <= cfg_wdata;
				REG_PLATEAU_SLOPE:   cfg_q.plateau_slope       <= cfg_wdata;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/pcpa_scale_lane.sv =====
// ---------------------------------------------------------------------------
// pcpa_scale_lane
// Pipelined slope * dt / 1000, truncated toward zero, as a signed increment.
// ---------------------------------------------------------------------------
module pcpa_scale_lane import pcpa_pkg::*; (
	input  logic            clk,
	input  stage_en_t       en,
	input  volt_t           slope,
	input  logic [DT_W-1:0] dt_s2,
	input  logic [DT_W-1:0] dt_s3,
	output inc_t            inc_s5
);

	localparam int PA_W = VOLT_W + RECIP_A_W;
	localparam int PB_W = P2_W + RECIP_B_W;

	logic              neg;
	logic [VOLT_W-1:0] mag_a;
	logic [PA_W-1:0]   prod_a;
	logic [AQ_W-1:0]   aq_s2;
	logic [AR_W-1:0]   alo_s2;
	logic              neg_s2;
	logic [AR_W-1:0]   ar_d;
	logic [P1_W-1:0]   p1_d;
	logic [P1_W-1:0]   p1_s3;
	logic [AR_W-1:0]   ar_s3;
	logic              neg_s3;
	logic [P2_W-1:0]   p2_d;
	logic [P2_W-1:0]   p2_s4;
	logic [P1_W-1:0]   p1_s4;
	logic              neg_s4;
	logic [PB_W-1:0]   prod_b;
	logic [MAG_W-1:0]  mag_d;
	inc_t              inc_d;

	// split |slope| into quotient and remainder of 1000
	assign neg    = slope[VOLT_W-1];
	assign mag_a  = neg ? VOLT_W'(-slope) : VOLT_W'(slope);
	assign prod_a = PA_W'(mag_a) * PA_W'(RECIP_A);

	always_ff @(posedge clk) begin
		if (en.ld2) begin
			aq_s2  <= prod_a[RECIP_A_SH +: AQ_W];
			alo_s2 <= mag_a[AR_W-1:0];
			neg_s2 <= neg;
		end
	end

	// remainder = |slope| - 1000*q, and -1000 is 24 modulo 1024
	assign ar_d = alo_s2 + AR_W'({aq_s2, 3'b000}) + AR_W'({aq_s2, 4'b0000});
	assign p1_d = P1_W'(aq_s2) * P1_W'(dt_s2);

	always_ff @(posedge clk) begin
		if (en.ld3) begin
			p1_s3  <= p1_d;
			ar_s3  <= ar_d;
			neg_s3 <= neg_s2;
		end
	end

	assign p2_d = P2_W'(ar_s3) * P2_W'(dt_s3);

	always_ff @(posedge clk) begin
		if (en.ld4) begin
			p2_s4  <= p2_d;
			p1_s4  <= p1_s3;
			neg_s4 <= neg_s3;
		end
	end

	assign prod_b = PB_W'(p2_s4) * PB_W'(RECIP_B);
	assign mag_d  = p1_s4 + MAG_W'(prod_b[RECIP_B_SH +: Q2_W]);
	assign inc_d  = neg_s4 ? -$signed({1'b0, mag_d}) : $signed({1'b0, mag_d});

	always_ff @(posedge clk) begin
		if (en.ld5) begin
			inc_s5 <= inc_d;
		end
	end

endmodule

// ===== hw/rtl/pcpa_cell_fsm.sv =====
// ---------------------------------------------------------------------------
// pcpa_cell_fsm
// Phase state machine, voltage update and result register.
// ---------------------------------------------------------------------------
module pcpa_cell_fsm import pcpa_pkg::*; #(
	parameter logic [DT_W-1:0] WAIT_MS    = WAIT_MS_DEF,
	parameter volt_t           VOLT_FLOOR = VOLT_FLOOR_DEF,
	parameter volt_t           VOLT_RESET = VOLT_RESET_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cfg_t            cfg,
	input  logic            step_valid,
	output logic            step_ready,
	input  logic [DT_W-1:0] dt,
	input  logic            stim,
	input  inc_t            inc [NUM_LANES],
	output logic            out_valid,
	input  logic            out_ready,
	output out_item_t       out_data
);

	phase_t            phase_q;
	phase_t            phase_d;
	volt_t             volt_q;
	volt_t             volt_d;
	logic [WAIT_W-1:0] wait_q;
	logic [WAIT_W-1:0] wait_d;
	logic [WAIT_W-1:0] wait_sum;
	logic              trig_q;
	logic              trig_d;
	logic              trig_set;
	logic              toggle_q;
	logic              moved;
	logic              load_reset;
	logic              res_valid_q;
	out_item_t         res_q;
	logic              fire;
	logic              dt_zero;
	volt_t             v_base;
	inc_t              inc_sel;
	logic signed [SUM_W-1:0] sum;
	volt_t             sat;

	assign step_ready = !res_valid_q || out_ready;
	assign fire       = step_valid && step_ready;
	assign dt_zero    = (dt == '0);
	assign trig_set   = trig_q | stim;
	assign wait_sum   = wait_q + WAIT_W'(dt);

	// phase exit decided from the voltage held before the tick
	always_comb begin
		phase_d    = phase_q;
		moved      = 1'b0;
		trig_d     = 1'b0;
		wait_d     = wait_q;
		load_reset = 1'b0;
		unique case (phase_q)
			PH_REST: begin
				trig_d = trig_set;
				if (trig_set || volt_q < cfg.rest_exit_level) begin
					trig_d = 1'b0;
					if (!cfg.pacing_disabled) begin
						phase_d = PH_UPSTROKE;
						moved   = 1'b1;
					end
				end
			end
			PH_UPSTROKE: begin
				if (volt_q >= cfg.upstroke_peak_level) begin
					phase_d = PH_PLATEAU;
					moved   = 1'b1;
				end
			end
			PH_PLATEAU: begin
				if (volt_q < cfg.plateau_exit_level) begin
					phase_d = PH_REPOL;
					moved   = 1'b1;
				end
			end
			PH_REPOL: begin
				if (volt_q < cfg.repol_exit_level) begin
					phase_d = PH_REST;
					moved   = 1'b1;
				end
			end
			default: begin
				trig_d = trig_set;
				wait_d = wait_sum;
				if (wait_sum >= {1'b0, WAIT_MS}) begin
					wait_d     = '0;
					load_reset = 1'b1;
					phase_d    = PH_REST;
					moved      = 1'b1;
				end
			end
		endcase
	end

	// voltage integration in the new phase
	always_comb begin
		v_base = load_reset ? VOLT_RESET : volt_q;
		unique case (phase_d)
			PH_UPSTROKE: inc_sel = inc[LANE_UP];
			PH_PLATEAU:  inc_sel = inc[LANE_PLAT];
			PH_REPOL:    inc_sel = inc[LANE_REPOL];
			default:     inc_sel = inc[LANE_REST];
		endcase
		sum = SUM_W'(v_base) + SUM_W'(inc_sel);
		if (sum > SUM_W'(VOLT_MAX)) begin
			sat = VOLT_MAX;
		end else if (sum < SUM_W'(VOLT_MIN)) begin
			sat = VOLT_MIN;
		end else begin
			sat = VOLT_W'(sum);
		end
		unique case (phase_d)
			PH_REST: begin
				volt_d = (!cfg.pacing_disabled && cfg.resting_slope != '0) ? sat : v_base;
			end
			PH_UPSTROKE: volt_d = (sat > cfg.upstroke_peak_level) ? cfg.upstroke_peak_level : sat;
			PH_PLATEAU:  volt_d = sat;
			PH_REPOL:    volt_d = (sat < VOLT_FLOOR) ? VOLT_FLOOR : sat;
			default:     volt_d = v_base;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_WAIT;
			volt_q      <= '0;
			wait_q      <= '0;
			trig_q      <= 1'b0;
			toggle_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (step_ready) begin
				res_valid_q <= step_valid;
			end
			if (fire && !dt_zero) begin
				phase_q  <= phase_d;
				volt_q   <= volt_d;
				wait_q   <= wait_d;
				trig_q   <= trig_d;
				toggle_q <= toggle_q ^ moved;
			end
		end
	end

	// a zero dt reports the held phase with voltage 0
	always_ff @(posedge clk) begin
		if (fire) begin
			res_q.voltage      <= dt_zero ? '0 : volt_d;
			res_q.phase        <= dt_zero ? phase_q : phase_d;
			res_q.phase_toggle <= dt_zero ? toggle_q : (toggle_q ^ moved);
		end
	end

	assign out_valid = res_valid_q;
	assign out_data  = res_q;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		wait_q < {1'b0, WAIT_MS})
		else $error("wait counter reached the wait length");

	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_REPOL) |-> (volt_q >= VOLT_FLOOR))
		else $error("repolarization voltage below floor");

	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && dt_zero) |=> (res_q.voltage == '0))
		else $error("zero dt tick gave nonzero voltage");

	assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ((phase_q != $past(phase_q)) == (toggle_q != $past(toggle_q))))
		else $error("toggle flag out of step with phase changes");
`endif

endmodule

// ===== hw/rtl/pacemaker_cell_phase_automaton_unit.sv =====
// ---------------------------------------------------------------------------
// pacemaker_cell_phase_automaton_unit
// Hybrid automaton model of a pacemaker cell: phase, voltage and toggle flag.
// Path: a tick passes through stages s1 to s5, then the result register.
// Throughput: one tick per cycle; the increment pipeline and the result
// register stall only when a result is held by the consumer.
// Reset: phase wait, voltage 0, counters and trigger clear, registers at
// their documented defaults.
// ---------------------------------------------------------------------------
module pacemaker_cell_phase_automaton_unit import pcpa_pkg::*; #(
	parameter logic [DT_W-1:0] WAIT_MS     = WAIT_MS_DEF,
	parameter volt_t           VOLT_FLOOR  = VOLT_FLOOR_DEF,
	parameter volt_t           VOLT_RESET  = VOLT_RESET_DEF,
	parameter volt_t           REPOL_SLOPE = REPOL_SLOPE_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [VOLT_W-1:0]    cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data
);

	cfg_t            cfg;
	stage_en_t       en;
	logic            ld1;
	logic            ld_res;
	logic            v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [DT_W-1:0] dt_s1, dt_s2, dt_s3, dt_s4, dt_s5;
	logic            stim_s1, stim_s2, stim_s3, stim_s4, stim_s5;
	volt_t           slopes [NUM_LANES];
	inc_t            incs [NUM_LANES];

	pcpa_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// a stage loads when it is empty or the next one loads
	assign en.ld5   = !v_s5 || ld_res;
	assign en.ld4   = !v_s4 || en.ld5;
	assign en.ld3   = !v_s3 || en.ld4;
	assign en.ld2   = !v_s2 || en.ld3;
	assign ld1      = !v_s1 || en.ld2;
	assign in_ready = ld1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (ld1) v_s1 <= in_valid;
			if (en.ld2) v_s2 <= v_s1;
			if (en.ld3) v_s3 <= v_s2;
			if (en.ld4) v_s4 <= v_s3;
			if (en.ld5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (ld1 && in_valid) begin
			dt_s1   <= in_data.dt_ms;
			stim_s1 <= in_data.stimulus;
		end
		if (en.ld2) begin
			dt_s2   <= dt_s1;
			stim_s2 <= stim_s1;
		end
		if (en.ld3) begin
			dt_s3   <= dt_s2;
			stim_s3 <= stim_s2;
		end
		if (en.ld4) begin
			dt_s4   <= dt_s3;
			stim_s4 <= stim_s3;
		end
		if (en.ld5) begin
			dt_s5   <= dt_s4;
			stim_s5 <= stim_s4;
		end
	end

	// every phase slope is scaled ahead; the state machine picks one
	assign slopes[LANE_REST]  = cfg.resting_slope;
	assign slopes[LANE_UP]    = cfg.upstroke_slope;
	assign slopes[LANE_PLAT]  = cfg.plateau_slope;
	assign slopes[LANE_REPOL] = REPOL_SLOPE;

	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		pcpa_scale_lane u_lane (
			.clk    (clk),
			.en     (en),
			.slope  (slopes[i]),
			.dt_s2  (dt_s2),
			.dt_s3  (dt_s3),
			.inc_s5 (incs[i])
		);
	end

	pcpa_cell_fsm #(
		.WAIT_MS    (WAIT_MS),
		.VOLT_FLOOR (VOLT_FLOOR),
		.VOLT_RESET (VOLT_RESET)
	) u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.step_valid (v_s5),
		.step_ready (ld_res),
		.dt         (dt_s5),
		.stim       (stim_s5),
		.inc        (incs),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

// ===== test/tb_pacemaker_cell_phase_automaton_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_pacemaker_cell_phase_automaton_unit
// Drives ticks into the cell automaton under several register settings and
// checks every result against a cycle-free model of phase, voltage and flag.
// ---------------------------------------------------------------------------
module tb_pacemaker_cell_phase_automaton_unit;
	import pcpa_pkg::*;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [VOLT_W-1:0]    cfg_wdata = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	in_item_t             in_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_item_t            out_data;

	pacemaker_cell_phase_automaton_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// shadow of the register file
	volt_t rest_drift = CFG_RESET.resting_slope;
	bit    pacing_off = CFG_RESET.pacing_disabled;
	volt_t rest_exit  = CFG_RESET.rest_exit_level;
	volt_t up_peak    = CFG_RESET.upstroke_peak_level;
	volt_t plat_exit  = CFG_RESET.plateau_exit_level;
	volt_t repol_exit = CFG_RESET.repol_exit_level;
	volt_t up_slope   = CFG_RESET.upstroke_slope;
	volt_t plat_slope = CFG_RESET.plateau_slope;

	// cell state as the block should hold it
	volt_t  cell_v    = '0;
	phase_t cell_ph   = PH_WAIT;
	int     wait_acc  = 0;
	bit     trig      = 1'b0;
	bit     toggle    = 1'b0;

	in_item_t  tick_q[$];
	out_item_t cell_expect_q[$];

	bit in_fire      = 1'b0;
	bit out_fire     = 1'b0;
	bit send_idle_en = 1'b1;
	bit recv_idle_en = 1'b1;
	int send_wait    = 0;
	int recv_wait    = 0;
	int drained      = 0;
	bit failed       = 1'b0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// voltage integration: slope*dt/1000 truncated toward zero, then saturated
	function automatic volt_t ramp(volt_t v, volt_t slope, logic [DT_W-1:0] dt);
		longint s;
		s = longint'(v) + (longint'(slope) * longint'(dt)) / 1000;
		if (s > longint'(VOLT_MAX))
			s = longint'(VOLT_MAX);
		if (s < longint'(VOLT_MIN))
			s = longint'(VOLT_MIN);
		return volt_t'(s);
	endfunction

	function automatic out_item_t advance_cell(in_item_t tick);
		out_item_t res;
		volt_t     v;
		bit        moved;
		v = cell_v;
		moved = 1'b0;
		if (tick.dt_ms == '0) begin
			res.voltage = '0;
			res.phase = cell_ph;
			res.phase_toggle = toggle;
			return res;
		end
		if (tick.stimulus)
			trig = 1'b1;
		// exit decision uses the voltage held before this tick
		case (cell_ph)
			PH_REST: begin
				if (trig || v < rest_exit) begin
					trig = 1'b0;
					if (!pacing_off) begin
						cell_ph = PH_UPSTROKE;
						moved = 1'b1;
					end
				end
			end
			PH_UPSTROKE: begin
				trig = 1'b0;
				if (v >= up_peak) begin
					cell_ph = PH_PLATEAU;
					moved = 1'b1;
				end
			end
			PH_PLATEAU: begin
				trig = 1'b0;
				if (v < plat_exit) begin
					cell_ph = PH_REPOL;
					moved = 1'b1;
				end
			end
			PH_REPOL: begin
				trig = 1'b0;
				if (v < repol_exit) begin
					cell_ph = PH_REST;
					moved = 1'b1;
				end
			end
			default: begin
				wait_acc += tick.dt_ms;
				if (wait_acc >= int'(WAIT_MS_DEF)) begin
					v = VOLT_RESET_DEF;
					cell_ph = PH_REST;
					wait_acc = 0;
					moved = 1'b1;
				end
			end
		endcase
		if (moved)
			toggle = !toggle;
		case (cell_ph)
			PH_REST: begin
				if (!pacing_off && rest_drift != 0)
					v = ramp(v, rest_drift, tick.dt_ms);
			end
			PH_UPSTROKE: begin
				v = ramp(v, up_slope, tick.dt_ms);
				if (v > up_peak)
					v = up_peak;
			end
			PH_PLATEAU: v = ramp(v, plat_slope, tick.dt_ms);
			PH_REPOL: begin
				v = ramp(v, REPOL_SLOPE_DEF, tick.dt_ms);
				if (v < VOLT_FLOOR_DEF)
					v = VOLT_FLOOR_DEF;
			end
			default: ;
		endcase
		cell_v = v;
		res.voltage = v;
		res.phase = cell_ph;
		res.phase_toggle = toggle;
		return res;
	endfunction

	// sender: holds the payload until the transfer, then idles for a drawn gap
	always @(negedge clk) begin : feed_ticks
		if (arst_n) begin
			if (in_valid && !in_fire) begin
				// hold
			end else if (send_wait > 0) begin
				send_wait--;
				in_valid <= 1'b0;
			end else if (tick_q.size() != 0) begin
				in_data <= tick_q.pop_front();
				in_valid <= 1'b1;
				send_wait = send_idle_en ? $urandom_range(0, 10) : 0;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: may stall after each transfer, with a long hold every 250 results
	always @(negedge clk) begin : drain_results
		if (arst_n) begin
			if (out_fire) begin
				drained++;
				if (drained % 250 == 0)
					recv_wait = 120;
				else
					recv_wait = recv_idle_en ? $urandom_range(0, 10) : 0;
			end else if (recv_wait > 0) begin
				recv_wait--;
			end
			out_ready <= (recv_wait == 0);
		end
	end

	always @(posedge clk) begin : check_results
		out_item_t want;
		in_fire <= arst_n && in_valid && in_ready;
		out_fire <= arst_n && out_valid && out_ready;
		if (arst_n) begin
			if (in_valid && in_ready)
				cell_expect_q.push_back(advance_cell(in_data));
			if (out_valid && out_ready) begin
				if (cell_expect_q.size() == 0) begin
					$error("result with no tick pending: %h", out_data);
					failed = 1'b1;
				end else begin
					want = cell_expect_q.pop_front();
					if (out_data.voltage !== want.voltage) begin
						$error("voltage: expected %0d, got %0d", want.voltage, out_data.voltage);
						failed = 1'b1;
					end
					if (out_data.phase !== want.phase) begin
						$error("phase: expected %0d, got %0d", want.phase, out_data.phase);
						failed = 1'b1;
					end
					if (out_data.phase_toggle !== want.phase_toggle) begin
						$error("phase_toggle: expected %0b, got %0b", want.phase_toggle,
							out_data.phase_toggle);
						failed = 1'b1;
					end
				end
			end
		end
	end

	task automatic queue_tick(int dt, bit stim);
		in_item_t t;
		t.dt_ms = dt[DT_W-1:0];
		t.stimulus = stim;
		tick_q.push_back(t);
	endtask

	// mostly short ticks so that every phase is passed through many times
	task automatic queue_random_ticks(int count);
		int pick;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 5)
				queue_tick(0, $urandom_range(0, 1));
			else if (pick < 10)
				queue_tick($urandom_range(0, 65535), $urandom_range(0, 1));
			else if (pick < 25)
				queue_tick($urandom_range(60, 1500), $urandom_range(0, 7) == 0);
			else
				queue_tick($urandom_range(1, 60), $urandom_range(0, 7) == 0);
		end
	endtask

	task automatic wait_drained();
		while (tick_q.size() != 0 || in_valid || cell_expect_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, volt_t val);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_RESTING_SLOPE:   rest_drift = val;
			REG_PACING_DISABLED: pacing_off = val[0];
			REG_REST_EXIT:       rest_exit = val;
			REG_UPSTROKE_PEAK:   up_peak = val;
			REG_PLATEAU_EXIT:    plat_exit = val;
			REG_REPOL_EXIT:      repol_exit = val;
			REG_UPSTROKE_SLOPE:  up_slope = val;
			REG_PLATEAU_SLOPE:   plat_slope = val;
			default: ;
		endcase
	endtask

	task automatic apply_settings(volt_t rs, bit pd, volt_t rx, volt_t pk, volt_t px,
			volt_t qx, volt_t us, volt_t ps);
		wait_drained();
		write_reg(REG_RESTING_SLOPE, rs);
		write_reg(REG_PACING_DISABLED, volt_t'(pd));
		write_reg(REG_REST_EXIT, rx);
		write_reg(REG_UPSTROKE_PEAK, pk);
		write_reg(REG_PLATEAU_EXIT, px);
		write_reg(REG_REPOL_EXIT, qx);
		write_reg(REG_UPSTROKE_SLOPE, us);
		write_reg(REG_PLATEAU_SLOPE, ps);
		@(negedge clk);
		cfg_wen <= 1'b0;
		send_idle_en = ($urandom_range(0, 3) != 0);
		recv_idle_en = ($urandom_range(0, 3) != 0);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// wait phase: zero dt, trigger held across wait, exact exit at the limit
		queue_tick(0, 1'b0);
		queue_tick(0, 1'b1);
		queue_tick(400, 1'b1);
		queue_tick(0, 1'b0);
		queue_tick(599, 1'b0);
		queue_tick(1, 1'b0);
		// pending trigger leaves rest, long ticks hit the upstroke ceiling
		queue_tick(1, 1'b0);
		queue_tick(65535, 1'b1);
		queue_tick(1, 1'b0);
		queue_tick(0, 1'b1);
		queue_tick(1000, 1'b1);
		queue_tick(3, 1'b0);
		// repolarization down to the floor, then rest exit on low voltage
		queue_tick(65535, 1'b0);
		queue_tick(7, 1'b0);
		queue_tick(5, 1'b0);
		queue_tick(32768, 1'b0);
		queue_tick(16'h5555, 1'b1);
		queue_tick(16'hAAAA, 1'b0);
		queue_random_ticks(250);

		// downward rest drift, rest exit only by voltage or trigger
		apply_settings(-24'sd5120, 1'b0, -24'sd19000, -24'sd7680, -24'sd10240,
			-24'sd16640, 24'sd256000, -24'sd2560);
		queue_random_ticks(200);

		// pacing off: cell parks in rest and drops triggers
		apply_settings(24'sd300000, 1'b1, -24'sd15360, -24'sd7680, -24'sd10240,
			-24'sd16640, 24'sd256000, -24'sd2560);
		queue_random_ticks(120);

		// upper extremes: every exit fires, sums saturate
		apply_settings(VOLT_MAX, 1'b0, VOLT_MAX, VOLT_MAX, VOLT_MAX, VOLT_MAX,
			VOLT_MAX, VOLT_MIN);
		queue_random_ticks(120);

		// lower extremes: upstroke clamps at the minimum, plateau never exits
		apply_settings(VOLT_MIN, 1'b0, VOLT_MIN, VOLT_MIN, VOLT_MIN, VOLT_MIN,
			VOLT_MIN, VOLT_MAX);
		queue_random_ticks(80);

		// moderate settings around the defaults
		apply_settings(volt_t'(int'($urandom_range(0, 20000)) - 10000), 1'b0,
			volt_t'(-15360 + int'($urandom_range(0, 4000)) - 2000),
			volt_t'(-7680 + int'($urandom_range(0, 4000)) - 2000),
			volt_t'(-10240 + int'($urandom_range(0, 2000)) - 1000),
			volt_t'(-16640 + int'($urandom_range(0, 2000)) - 1000),
			volt_t'(int'($urandom_range(100000, 500000))),
			volt_t'(-int'($urandom_range(1000, 8000))));
		queue_random_ticks(230);

		wait_drained();
		repeat (20) @(posedge clk);
		if (!failed && cell_expect_q.size() == 0)
			$display("[pacemaker_cell_phase_automaton_unit] OK");
		else
			$display("[pacemaker_cell_phase_automaton_unit] ERROR");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("[pacemaker_cell_phase_automaton_unit] ERROR");
		$finish;
	end

endmodule
